[design/ccvf_pkg.sv]
// ----------------------------------------------------------------------------
// ccvf_pkg
// Shared types and constants for the cube cell volume fraction pipeline.
// ----------------------------------------------------------------------------
package ccvf_pkg;

  localparam int OFS_W    = 25;  // plane offset, signed
  localparam int NORM_W   = 16;  // normal components, signed
  localparam int SIZE_W   = 24;  // cell extents, unsigned
  localparam int PROD_W   = 39;  // size times normal magnitude
  localparam int REGION_W = 4;   // signed region code
  localparam int MUL_DIGIT = 8;  // multiplier digit per pipeline stage

  typedef enum logic [2:0] {
    RG_FULL    = 3'd0,
    RG_CORNER  = 3'd1,
    RG_EDGE    = 3'd2,
    RG_WEDGE   = 3'd3,
    RG_HEXAGON = 3'd4,
    RG_SQUARE  = 3'd5
  } region_e;

endpackage

[design/ccvf_mul.sv]
// ----------------------------------------------------------------------------
// ccvf_mul
// Pipelined unsigned multiplier, one digit of the second operand per stage.
// ----------------------------------------------------------------------------
module ccvf_mul #(
  parameter int WA = 16,
  parameter int WB = 16
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [WA-1:0] a_i,
  input  logic [WB-1:0] b_i,
  output logic [WA+WB-1:0] p_o
);
  import ccvf_pkg::*;

  localparam int WD  = MUL_DIGIT;
  localparam int NS  = (WB + WD - 1) / WD;
  localparam int WBP = NS * WD;
  localparam int WP  = WA + WB;

  // operand carry registers exist for stages 0..NS-2
  logic [WA-1:0]    a_q [NS-1];
  logic [WBP-1:0]   b_q [NS-1];
  logic [WP-1:0]    p_q [NS];
  logic [WA+WD-1:0] pp  [NS];
  logic [WBP-1:0]   b_pad;

  assign b_pad = WBP'(b_i);

  for (genvar k = 0; k < NS; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign pp[k] = (WA+WD)'(a_i) * (WA+WD)'(b_pad[WD-1:0]);
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          a_q[k] <= a_i;
          b_q[k] <= b_pad;
          p_q[k] <= WP'(pp[k]);
        end
      end
    end else begin : g_next
      assign pp[k] = (WA+WD)'(a_q[k-1]) * (WA+WD)'(b_q[k-1][k*WD +: WD]);
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          p_q[k] <= p_q[k-1] + (WP'(pp[k]) << (k*WD));
        end
      end
      if (k < NS - 1) begin : g_carry
        always_ff @(posedge clk_i) begin
          if (en_i) begin
            a_q[k] <= a_q[k-1];
            b_q[k] <= b_q[k-1];
          end
        end
      end
    end
  end

  assign p_o = p_q[NS-1];

endmodule

[design/ccvf_dly.sv]
// ----------------------------------------------------------------------------
// ccvf_dly
// Delay line for side data and valid bits alongside a pipelined unit.
// ----------------------------------------------------------------------------
module ccvf_dly #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         vld_i,
  input  logic [W-1:0] d_i,
  output logic         vld_o,
  output logic [W-1:0] d_o
);

  logic         vld_q [N];
  logic [W-1:0] d_q   [N];

  for (genvar k = 0; k < N; k++) begin : g_tap
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= (k == 0) ? vld_i : vld_q[(k == 0) ? 0 : k-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q[k] <= (k == 0) ? d_i : d_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign vld_o = vld_q[N-1];
  assign d_o   = d_q[N-1];

endmodule

[design/ccvf_div.sv]
// ----------------------------------------------------------------------------
// ccvf_div
// Pipelined restoring divider, one quotient bit per stage, quotient limited
// to one half of full scale.
// ----------------------------------------------------------------------------
module ccvf_div #(
  parameter int WNUM = 32,
  parameter int WDEN = 16,
  parameter int QW   = 16
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [WNUM-1:0] num_i,
  input  logic [WDEN-1:0] den_i,
  output logic [QW-1:0]   q_o
);

  localparam int WR = (WNUM > WDEN + QW) ? WNUM : WDEN + QW;
  localparam logic [QW-1:0] HALF = QW'(1) << (QW - 1);

  logic [WR-1:0] rem_q [QW];
  logic [WR-1:0] den_q [QW];
  logic [QW-1:0] q_q   [QW];
  logic          cap_q [QW];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= WR'(num_i);
      den_q[0] <= WR'(den_i);
      q_q[0]   <= '0;
      cap_q[0] <= WR'(num_i) >= (WR'(den_i) << (QW - 1));
    end
  end

  for (genvar s = 1; s < QW; s++) begin : g_bit
    localparam int K = QW - 1 - s;
    logic [WR-1:0] trial;
    logic          take;
    assign trial = den_q[s-1] << K;
    assign take  = !cap_q[s-1] && (rem_q[s-1] >= trial);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= take ? rem_q[s-1] - trial : rem_q[s-1];
        den_q[s] <= den_q[s-1];
        q_q[s]   <= q_q[s-1] | (QW'(take) << K);
        cap_q[s] <= cap_q[s-1];
      end
    end
  end

  assign q_o = cap_q[QW-1] ? HALF : q_q[QW-1];

endmodule

[design/cube_cell_volume_fraction.sv]
// ----------------------------------------------------------------------------
// cube_cell_volume_fraction
// Volume fraction of a box cell below a cutting plane, one cell per cycle.
//
//   channel  signals                                   direction
//   in       in_valid_i, in_stall_o, plane_offset_i,   into block
//            normal_x/y/z_i, size_x/y/z_i
//   out      out_valid_o, out_stall_i, fraction_o,     out of block
//            region_o, degenerate_o
//
// One cell enters per cycle while the output is not stalled. The depth is
// set by the two multiplier levels, which depend on WU = max(NORMAL_BITS + 26,
// 41), and by the one-bit-per-stage divider, which depends on FRAC_BITS.
// Reset clears the valid bits only; there is no state between cells.
// A stalled output freezes the whole pipeline; in_stall_o follows it.
// ----------------------------------------------------------------------------
module cube_cell_volume_fraction #(
  parameter int FRAC_BITS   = 16,
  parameter int NORMAL_BITS = 14
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [ccvf_pkg::OFS_W-1:0]    plane_offset_i,
  input  logic signed [ccvf_pkg::NORM_W-1:0]   normal_x_i,
  input  logic signed [ccvf_pkg::NORM_W-1:0]   normal_y_i,
  input  logic signed [ccvf_pkg::NORM_W-1:0]   normal_z_i,
  input  logic        [ccvf_pkg::SIZE_W-1:0]   size_x_i,
  input  logic        [ccvf_pkg::SIZE_W-1:0]   size_y_i,
  input  logic        [ccvf_pkg::SIZE_W-1:0]   size_z_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic        [FRAC_BITS:0]            fraction_o,
  output logic signed [ccvf_pkg::REGION_W-1:0] region_o,
  output logic                                 degenerate_o
);
  import ccvf_pkg::*;

  localparam int WX   = OFS_W + NORMAL_BITS + 1;
  localparam int WS   = PROD_W + 2;
  localparam int WU   = (WX > WS) ? WX : WS;
  localparam int WP   = 2 * WU;
  localparam int WI   = WP + 4;
  localparam int WQ   = 3 * WU;
  localparam int WN   = WQ + 9;
  localparam int WNUM = WN + FRAC_BITS + 1;
  localparam logic [FRAC_BITS:0] HALF = (FRAC_BITS+1)'(1) << (FRAC_BITS - 1);
  localparam logic [FRAC_BITS:0] ONE  = HALF << 1;

  typedef struct packed {
    region_e       region;
    logic          pos;
    logic          neg;
    logic          degen;
  } flags_t;

  typedef struct packed {
    flags_t        fl;
    logic [WU-1:0] x2;
    logic [WU-1:0] c;
    logic [WU-1:0] u;
  } side1_t;

  typedef struct packed {
    flags_t        fl;
    logic [WU-1:0] x2;
    logic [WU-1:0] c;
    logic [WI-1:0] sub2;
    logic [WI-1:0] bc12;
  } side2_t;

  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // stage 1: magnitudes
  logic              s1_vld_q, s1_pos_q, s1_neg_q;
  logic [OFS_W-1:0]  s1_mag_q, ofs_mag_d;
  logic [NORM_W-1:0] s1_nx_q, s1_ny_q, s1_nz_q, nx_d, ny_d, nz_d;
  logic [SIZE_W-1:0] s1_sx_q, s1_sy_q, s1_sz_q;

  assign ofs_mag_d = plane_offset_i[OFS_W-1] ? (~plane_offset_i + 1'b1) : plane_offset_i;
  assign nx_d = normal_x_i[NORM_W-1] ? (~normal_x_i + 1'b1) : normal_x_i;
  assign ny_d = normal_y_i[NORM_W-1] ? (~normal_y_i + 1'b1) : normal_y_i;
  assign nz_d = normal_z_i[NORM_W-1] ? (~normal_z_i + 1'b1) : normal_z_i;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_mag_q <= ofs_mag_d;
      s1_pos_q <= !plane_offset_i[OFS_W-1] && (ofs_mag_d != '0);
      s1_neg_q <= plane_offset_i[OFS_W-1];
      s1_nx_q  <= nx_d;
      s1_ny_q  <= ny_d;
      s1_nz_q  <= nz_d;
      s1_sx_q  <= size_x_i;
      s1_sy_q  <= size_y_i;
      s1_sz_q  <= size_z_i;
    end
  end

  // stage 2: scaled normal products, doubled offset
  logic              s2_vld_q, s2_pos_q, s2_neg_q;
  logic [PROD_W-1:0] s2_a_q, s2_b_q, s2_c_q;
  logic [WU-1:0]     s2_x2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_a_q   <= PROD_W'(s1_sx_q) * PROD_W'(s1_nx_q);
      s2_b_q   <= PROD_W'(s1_sy_q) * PROD_W'(s1_ny_q);
      s2_c_q   <= PROD_W'(s1_sz_q) * PROD_W'(s1_nz_q);
      s2_x2_q  <= WU'(s1_mag_q) << (NORMAL_BITS + 1);
      s2_pos_q <= s1_pos_q;
      s2_neg_q <= s1_neg_q;
    end
  end

  // stages 3 to 5: sorting network
  logic              s3_vld_q, s3_pos_q, s3_neg_q;
  logic              s4_vld_q, s4_pos_q, s4_neg_q;
  logic              s5_vld_q, s5_pos_q, s5_neg_q;
  logic [PROD_W-1:0] s3_a_q, s3_b_q, s3_c_q, s4_a_q, s4_b_q, s4_c_q;
  logic [PROD_W-1:0] s5_a_q, s5_b_q, s5_c_q;
  logic [WU-1:0]     s3_x2_q, s4_x2_q, s5_x2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_a_q   <= (s2_a_q > s2_b_q) ? s2_b_q : s2_a_q;
      s3_b_q   <= (s2_a_q > s2_b_q) ? s2_a_q : s2_b_q;
      s3_c_q   <= s2_c_q;
      s3_x2_q  <= s2_x2_q;
      s3_pos_q <= s2_pos_q;
      s3_neg_q <= s2_neg_q;
      s4_a_q   <= s3_a_q;
      s4_b_q   <= (s3_b_q > s3_c_q) ? s3_c_q : s3_b_q;
      s4_c_q   <= (s3_b_q > s3_c_q) ? s3_b_q : s3_c_q;
      s4_x2_q  <= s3_x2_q;
      s4_pos_q <= s3_pos_q;
      s4_neg_q <= s3_neg_q;
      s5_a_q   <= (s4_a_q > s4_b_q) ? s4_b_q : s4_a_q;
      s5_b_q   <= (s4_a_q > s4_b_q) ? s4_a_q : s4_b_q;
      s5_c_q   <= s4_c_q;
      s5_x2_q  <= s4_x2_q;
      s5_pos_q <= s4_pos_q;
      s5_neg_q <= s4_neg_q;
    end
  end

  // stage 6: section bounds
  logic          s6_vld_q, s6_pos_q, s6_neg_q, s6_degen_q, s6_ablec_q;
  logic [WU-1:0] s6_a_q, s6_b_q, s6_c_q, s6_x2_q, s6_sum_q, s6_gabs_q;
  logic [WU-1:0] s6_acb_q, s6_bca_q, s6_w_q, s6_y_q, s6_h_q;
  logic [WU-1:0] ea, eb, ec, sab_d;

  assign ea    = WU'(s5_a_q);
  assign eb    = WU'(s5_b_q);
  assign ec    = WU'(s5_c_q);
  assign sab_d = ea + eb;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s6_a_q     <= ea;
      s6_b_q     <= eb;
      s6_c_q     <= ec;
      s6_x2_q    <= s5_x2_q;
      s6_sum_q   <= sab_d + ec;
      s6_gabs_q  <= (sab_d >= ec) ? sab_d - ec : ec - sab_d;
      s6_ablec_q <= sab_d <= ec;
      s6_acb_q   <= ea + ec - eb;
      s6_bca_q   <= eb + ec - ea;
      s6_w_q     <= sab_d + ec - s5_x2_q;
      s6_y_q     <= s5_x2_q + sab_d - ec;
      s6_h_q     <= sab_d - ec;
      s6_degen_q <= s5_c_q == '0;
      s6_pos_q   <= s5_pos_q;
      s6_neg_q   <= s5_neg_q;
    end
  end

  // stage 7: region and multiplier operands
  logic          s7_vld_q;
  side1_t        s7_side_q;
  logic [WU-1:0] s7_a_q, s7_b_q, s7_c_q, s7_u_q, s7_u2_q, s7_t_q;
  region_e       region_d;
  logic [WU-1:0] two_a, v_d, u_d, u2_d, t_d;

  assign two_a = s6_a_q << 1;
  assign v_d   = (s6_w_q >= two_a) ? s6_w_q - two_a : '0;

  always_comb begin
    priority if (s6_x2_q <= s6_gabs_q) region_d = s6_ablec_q ? RG_SQUARE : RG_HEXAGON;
    else if (s6_x2_q < s6_acb_q)       region_d = RG_WEDGE;
    else if (s6_x2_q <= s6_bca_q)      region_d = RG_EDGE;
    else if (s6_x2_q <= s6_sum_q)      region_d = RG_CORNER;
    else                               region_d = RG_FULL;
  end

  always_comb begin
    unique case (region_d)
      RG_HEXAGON: begin u_d = s6_x2_q; u2_d = s6_x2_q; t_d = s6_h_q; end
      RG_WEDGE:   begin u_d = s6_y_q;  u2_d = s6_y_q;  t_d = '0;     end
      RG_EDGE:    begin u_d = s6_w_q;  u2_d = v_d;     t_d = s6_a_q; end
      RG_CORNER:  begin u_d = s6_w_q;  u2_d = s6_w_q;  t_d = '0;     end
      default:    begin u_d = s6_x2_q; u2_d = s6_x2_q; t_d = '0;     end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s7_a_q  <= s6_a_q;
      s7_b_q  <= s6_b_q;
      s7_c_q  <= s6_c_q;
      s7_u_q  <= u_d;
      s7_u2_q <= u2_d;
      s7_t_q  <= t_d;
      s7_side_q.fl.region <= region_d;
      s7_side_q.fl.pos    <= s6_pos_q;
      s7_side_q.fl.neg    <= s6_neg_q;
      s7_side_q.fl.degen  <= s6_degen_q;
      s7_side_q.x2        <= s6_x2_q;
      s7_side_q.c         <= s6_c_q;
      s7_side_q.u         <= u_d;
    end
  end

  // first multiplier level
  logic [WP-1:0] m1_p, m2_p, m3_p, m4_p;
  logic          d1_vld;
  side1_t        d1_side;

  ccvf_mul #(.WA(WU), .WB(WU)) u_mul_ab (
    .clk_i(clk_i), .en_i(adv), .a_i(s7_a_q), .b_i(s7_b_q), .p_o(m1_p));
  ccvf_mul #(.WA(WU), .WB(WU)) u_mul_bc (
    .clk_i(clk_i), .en_i(adv), .a_i(s7_b_q), .b_i(s7_c_q), .p_o(m2_p));
  ccvf_mul #(.WA(WU), .WB(WU)) u_mul_uu (
    .clk_i(clk_i), .en_i(adv), .a_i(s7_u_q), .b_i(s7_u2_q), .p_o(m3_p));
  ccvf_mul #(.WA(WU), .WB(WU)) u_mul_tt (
    .clk_i(clk_i), .en_i(adv), .a_i(s7_t_q), .b_i(s7_t_q), .p_o(m4_p));

  ccvf_dly #(.W($bits(side1_t)), .N((WU + MUL_DIGIT - 1) / MUL_DIGIT)) u_dly1 (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(adv),
    .vld_i(s7_vld_q), .d_i(s7_side_q), .vld_o(d1_vld), .d_o(d1_side));

  // hexagon inner term and edge terms
  logic          si_vld_q;
  side2_t        si_side_q;
  logic [WP-1:0] si_pab_q, si_s1_q;
  logic [WI-1:0] si_sel_q;
  logic [WU-1:0] si_c_q, si_u_q, si_x2_q;
  logic [WI-1:0] pab_w, bc_w, s1_w, t2_w, prod12, subt, inner;

  assign pab_w  = WI'(m1_p);
  assign bc_w   = WI'(m2_p);
  assign s1_w   = WI'(m3_p);
  assign t2_w   = WI'(m4_p);
  assign prod12 = (pab_w << 3) + (pab_w << 2);
  assign subt   = (t2_w << 1) + t2_w + s1_w;
  assign inner  = (prod12 > subt) ? prod12 - subt : '0;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      si_pab_q <= m1_p;
      si_s1_q  <= m3_p;
      si_sel_q <= (d1_side.fl.region == RG_HEXAGON) ? inner : pab_w;
      si_c_q   <= d1_side.c;
      si_u_q   <= d1_side.u;
      si_x2_q  <= d1_side.x2;
      si_side_q.fl   <= d1_side.fl;
      si_side_q.x2   <= d1_side.x2;
      si_side_q.c    <= d1_side.c;
      si_side_q.sub2 <= (s1_w << 1) + s1_w + (t2_w << 2);
      si_side_q.bc12 <= (bc_w << 3) + (bc_w << 2);
    end
  end

  // second multiplier level
  logic [WQ-1:0]   m5_p, m6_p;
  logic [WQ+3:0]   m7_p;
  logic            d2_vld;
  side2_t          d2_side;

  ccvf_mul #(.WA(WP), .WB(WU)) u_mul_abc (
    .clk_i(clk_i), .en_i(adv), .a_i(si_pab_q), .b_i(si_c_q), .p_o(m5_p));
  ccvf_mul #(.WA(WP), .WB(WU)) u_mul_cube (
    .clk_i(clk_i), .en_i(adv), .a_i(si_s1_q), .b_i(si_u_q), .p_o(m6_p));
  ccvf_mul #(.WA(WI), .WB(WU)) u_mul_x (
    .clk_i(clk_i), .en_i(adv), .a_i(si_sel_q), .b_i(si_x2_q), .p_o(m7_p));

  ccvf_dly #(.W($bits(side2_t)), .N((WU + MUL_DIGIT - 1) / MUL_DIGIT)) u_dly2 (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(adv),
    .vld_i(si_vld_q), .d_i(si_side_q), .vld_o(d2_vld), .d_o(d2_side));

  // compose numerator and denominator
  logic          c1_vld_q, c2_vld_q, c3_vld_q;
  flags_t        c1_fl_q, c2_fl_q, c3_fl_q;
  logic [WN-1:0] c1_abc12_q, c1_abc24_q, c1_m7_q, c1_m7x24_q, c1_cube_q;
  logic [WN-1:0] c1_sub2_q, c1_bc12_q, c1_x2_q, c1_c_q;
  logic [WN-1:0] abc_n, m7_n, n_d, d_d;
  logic [WN-1:0] c2_n_q, c2_d_q;
  logic [WNUM-1:0] c3_num_q;
  logic [WN:0]     c3_den_q;

  assign abc_n = WN'(m5_p);
  assign m7_n  = WN'(m7_p);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c1_abc12_q <= (abc_n << 3) + (abc_n << 2);
      c1_abc24_q <= (abc_n << 4) + (abc_n << 3);
      c1_m7_q    <= m7_n;
      c1_m7x24_q <= (m7_n << 4) + (m7_n << 3);
      c1_cube_q  <= WN'(m6_p);
      c1_sub2_q  <= WN'(d2_side.sub2);
      c1_bc12_q  <= WN'(d2_side.bc12);
      c1_x2_q    <= WN'(d2_side.x2);
      c1_c_q     <= WN'(d2_side.c);
      c1_fl_q    <= d2_side.fl;
    end
  end

  always_comb begin
    unique case (c1_fl_q.region)
      RG_SQUARE:  begin n_d = c1_x2_q; d_d = c1_c_q; end
      RG_HEXAGON: begin n_d = c1_m7_q; d_d = c1_abc12_q; end
      RG_WEDGE: begin
        n_d = (c1_m7x24_q > c1_cube_q) ? c1_m7x24_q - c1_cube_q : '0;
        d_d = c1_abc24_q;
      end
      RG_EDGE: begin
        n_d = (c1_bc12_q > c1_sub2_q) ? c1_bc12_q - c1_sub2_q : '0;
        d_d = c1_bc12_q;
      end
      RG_CORNER: begin
        n_d = (c1_abc24_q > c1_cube_q) ? c1_abc24_q - c1_cube_q : '0;
        d_d = c1_abc24_q;
      end
      default: begin n_d = '0; d_d = '0; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c2_n_q   <= n_d;
      c2_d_q   <= d_d;
      c2_fl_q  <= c1_fl_q;
      c3_num_q <= (WNUM'(c2_n_q) << FRAC_BITS) + WNUM'(c2_d_q);
      c3_den_q <= {c2_d_q, 1'b0};
      c3_fl_q  <= c2_fl_q;
    end
  end

  // rounded, limited quotient
  logic [FRAC_BITS-1:0] div_q;
  logic                 d3_vld;
  flags_t               d3_fl;

  ccvf_div #(.WNUM(WNUM), .WDEN(WN + 1), .QW(FRAC_BITS)) u_div (
    .clk_i(clk_i), .en_i(adv), .num_i(c3_num_q), .den_i(c3_den_q), .q_o(div_q));

  ccvf_dly #(.W($bits(flags_t)), .N(FRAC_BITS)) u_dly3 (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(adv),
    .vld_i(c3_vld_q), .d_i(c3_fl_q), .vld_o(d3_vld), .d_o(d3_fl));

  // output register
  logic                        out_vld_q;
  logic [FRAC_BITS:0]          frac_q, q_d, frac_d;
  logic signed [REGION_W-1:0]  region_q;
  logic                        degen_q;

  always_comb begin
    q_d = (d3_fl.region == RG_FULL) ? HALF : (FRAC_BITS+1)'(div_q);
    priority if (d3_fl.degen) frac_d = HALF;
    else if (d3_fl.pos)       frac_d = HALF + q_d;
    else if (d3_fl.neg)       frac_d = HALF - q_d;
    else                      frac_d = HALF;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      frac_q   <= frac_d;
      region_q <= d3_fl.pos ? REGION_W'(d3_fl.region)
                            : REGION_W'(0) - REGION_W'(d3_fl.region);
      degen_q  <= d3_fl.degen;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      s6_vld_q  <= 1'b0;
      s7_vld_q  <= 1'b0;
      si_vld_q  <= 1'b0;
      c1_vld_q  <= 1'b0;
      c2_vld_q  <= 1'b0;
      c3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= in_valid_i;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      s5_vld_q  <= s4_vld_q;
      s6_vld_q  <= s5_vld_q;
      s7_vld_q  <= s6_vld_q;
      si_vld_q  <= d1_vld;
      c1_vld_q  <= d2_vld;
      c2_vld_q  <= c1_vld_q;
      c3_vld_q  <= c2_vld_q;
      out_vld_q <= d3_vld;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign fraction_o   = frac_q;
  assign region_o     = region_q;
  assign degenerate_o = degen_q;

  a_degen_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> fraction_o == HALF)
    else $error("degenerate cell without one half fraction");

  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fraction_o <= ONE)
    else $error("fraction above one");

  a_pos_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !region_o[REGION_W-1] && region_o != '0 && !degenerate_o
      |-> fraction_o >= HALF)
    else $error("positive offset with fraction below one half");

  a_neg_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && region_o[REGION_W-1] |-> fraction_o <= HALF)
    else $error("negative region code with fraction above one half");

endmodule
